@@ hw/rtl/smne_pkg.sv @@
// Shared types, codes and constants of the S-curve mean and noise extractor.
package smne_pkg;

    localparam logic REQ_SAMPLE = 1'b0;
    localparam logic REQ_FINISH = 1'b1;

    localparam int W_BITS  = 18;
    localparam int M1_BITS = 48;
    localparam int M2_BITS = 64;
    localparam int OCC_BITS = 16;
    localparam int CH_BITS = 8;
    localparam int OUT_BITS = 14;

    localparam logic [OUT_BITS-1:0] OUT_MAX = 14'h3FFF;

    localparam logic [1:0] STATUS_NONE      = 2'b00;
    localparam logic [1:0] STATUS_ZERO_WT   = 2'b11;
    localparam logic [1:0] STATUS_NEG_VAR   = 2'b10;

    localparam int DIV_NUM_BITS = 53;
    localparam int DIV_DEN_BITS = 19;
    localparam int DD_BITS      = 99;
    localparam int LIM_BITS     = 106;

    typedef struct packed {
        logic [CH_BITS-1:0] channel;
        logic [W_BITS-1:0]  w;
        logic [M1_BITS-1:0] m1;
        logic [M2_BITS-1:0] m2;
    } smne_entry_t;

    typedef enum logic [1:0] {
        F_IDLE,
        F_READ,
        F_MUL,
        F_WRITE
    } smne_front_state_t;

    typedef enum logic [3:0] {
        B_IDLE,
        B_P0,
        B_P1,
        B_P2,
        B_Q0,
        B_Q1,
        B_Q2,
        B_D,
        B_DIV,
        B_SQ_X,
        B_SQ_M,
        B_SQ_C,
        B_OUT
    } smne_back_state_t;

endpackage

@@ hw/rtl/smne_ram.sv @@
// Generic single-port-write, single-port-read RAM with registered read data.
module smne_ram
    #(
        parameter int WIDTH = 8,
        parameter int DEPTH = 16,
        localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
    )
    (
        input  logic             clk,
        input  logic             we,
        input  logic [AW-1:0]    waddr,
        input  logic [WIDTH-1:0] wdata,
        input  logic             re,
        input  logic [AW-1:0]    raddr,
        output logic [WIDTH-1:0] rdata
    );

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

@@ hw/rtl/smne_front.sv @@
// Front end: accepts requests, accumulates samples per channel and queues finish requests.
module smne_front
    import smne_pkg::*;
    #(
        parameter int CHANNELS = 256,
        parameter int THRESH_BITS = 10
    )
    (
        input  logic                   clk,
        input  logic                   rst_n,
        input  logic                   start,
        output logic                   busy,
        input  logic                   req_type,
        input  logic [CH_BITS-1:0]     channel,
        input  logic [THRESH_BITS-1:0] threshold,
        input  logic [OCC_BITS-1:0]    occupancy,
        input  logic                   q_full,
        output logic                   push,
        output smne_entry_t            push_entry
    );

    localparam int AW  = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int CW  = THRESH_BITS + 1;
    localparam int DW  = OCC_BITS + 1;
    localparam int P1W = CW + 1 + DW;
    localparam int SQW = 2 * CW;
    localparam int P2W = SQW + 1 + DW;
    localparam int O_M1  = M2_BITS;
    localparam int O_W   = O_M1 + M1_BITS;
    localparam int O_OCC = O_W + W_BITS;
    localparam int O_T   = O_OCC + OCC_BITS;
    localparam int RW    = O_T + THRESH_BITS;

    smne_front_state_t state_reg, state_next;
    logic                   req_reg, req_next;
    logic [CH_BITS-1:0]     ch_reg, ch_next;
    logic [THRESH_BITS-1:0] t_reg, t_next;
    logic [OCC_BITS-1:0]    occ_reg, occ_next;
    logic signed [DW-1:0]   d_reg, d_next;
    logic [SQW-1:0]         c2sq_reg, c2sq_next;
    logic signed [P1W-1:0]  p1_reg, p1_next;
    logic signed [P2W-1:0]  p2_reg, p2_next;
    logic [CHANNELS-1:0]    has_prev_reg, has_prev_next;

    logic                   ram_we, ram_re;
    logic [RW-1:0]          ram_wdata, ram_rdata;
    logic [AW-1:0]          ch_addr, in_addr;
    logic                   ch_ok, valid;
    logic [THRESH_BITS-1:0] prev_t;
    logic [OCC_BITS-1:0]    prev_occ;
    logic [W_BITS-1:0]      rd_w;
    logic [M1_BITS-1:0]     rd_m1;
    logic [M2_BITS-1:0]     rd_m2;
    logic [CW-1:0]          c2;
    logic signed [DW-1:0]   d_now;

    assign in_addr  = AW'(channel);
    assign ch_addr  = AW'(ch_reg);
    assign ch_ok    = (int'(channel) < CHANNELS);
    assign busy     = (state_reg != F_IDLE) || q_full;
    assign valid    = has_prev_reg[ch_addr];
    assign prev_t   = ram_rdata[O_T +: THRESH_BITS];
    assign prev_occ = ram_rdata[O_OCC +: OCC_BITS];
    assign rd_w     = ram_rdata[O_W +: W_BITS];
    assign rd_m1    = ram_rdata[O_M1 +: M1_BITS];
    assign rd_m2    = ram_rdata[0 +: M2_BITS];
    assign c2       = {1'b0, prev_t} + {1'b0, t_reg};
    assign d_now    = $signed({1'b0, prev_occ}) - $signed({1'b0, occ_reg});

    smne_ram #(.WIDTH(RW), .DEPTH(CHANNELS)) u_ram
    (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ch_addr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (in_addr),
        .rdata (ram_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= F_IDLE;
            has_prev_reg <= '0;
        end
        else
        begin
            state_reg    <= state_next;
            has_prev_reg <= has_prev_next;
        end
    end

    always_ff @(posedge clk)
    begin
        req_reg  <= req_next;
        ch_reg   <= ch_next;
        t_reg    <= t_next;
        occ_reg  <= occ_next;
        d_reg    <= d_next;
        c2sq_reg <= c2sq_next;
        p1_reg   <= p1_next;
        p2_reg   <= p2_next;
    end

    always_comb
    begin
        state_next    = state_reg;
        req_next      = req_reg;
        ch_next       = ch_reg;
        t_next        = t_reg;
        occ_next      = occ_reg;
        d_next        = d_reg;
        c2sq_next     = c2sq_reg;
        p1_next       = p1_reg;
        p2_next       = p2_reg;
        has_prev_next = has_prev_reg;
        ram_we        = 1'b0;
        ram_re        = 1'b0;
        ram_wdata     = '0;
        push          = 1'b0;
        push_entry    = '0;
        unique case (state_reg)
            F_IDLE:
            begin
                if (start && !busy && ch_ok)
                begin
                    ram_re     = 1'b1;
                    req_next   = req_type;
                    ch_next    = channel;
                    t_next     = threshold;
                    occ_next   = occupancy;
                    state_next = F_READ;
                end
            end
            F_READ:
            begin
                if (req_reg == REQ_FINISH)
                begin
                    push               = 1'b1;
                    push_entry.channel = ch_reg;
                    push_entry.w       = valid ? rd_w : '0;
                    push_entry.m1      = valid ? rd_m1 : '0;
                    push_entry.m2      = valid ? rd_m2 : '0;
                    has_prev_next[ch_addr] = 1'b0;
                    state_next = F_IDLE;
                end
                else if (!valid)
                begin
                    ram_we    = 1'b1;
                    ram_wdata = {t_reg, occ_reg, W_BITS'(0), M1_BITS'(0), M2_BITS'(0)};
                    has_prev_next[ch_addr] = 1'b1;
                    state_next = F_IDLE;
                end
                else
                begin
                    d_next     = d_now;
                    c2sq_next  = c2 * c2;
                    p1_next    = $signed({1'b0, c2}) * d_now;
                    state_next = F_MUL;
                end
            end
            F_MUL:
            begin
                p2_next    = $signed({1'b0, c2sq_reg}) * d_reg;
                state_next = F_WRITE;
            end
            F_WRITE:
            begin
                ram_we    = 1'b1;
                ram_wdata = {t_reg, occ_reg,
                             rd_w + {{(W_BITS-DW){d_reg[DW-1]}}, d_reg},
                             rd_m1 + {{(M1_BITS-P1W){p1_reg[P1W-1]}}, p1_reg},
                             rd_m2 + {{(M2_BITS-P2W){p2_reg[P2W-1]}}, p2_reg}};
                state_next = F_IDLE;
            end
            default:
            begin
                state_next = F_IDLE;
            end
        endcase
    end

endmodule

@@ hw/rtl/smne_queue.sv @@
// Two-entry queue that carries finish transactions from the front end to the back end.
module smne_queue
    import smne_pkg::*;
    (
        input  logic        clk,
        input  logic        rst_n,
        input  logic        push,
        input  smne_entry_t push_entry,
        output logic        full,
        input  logic        pop,
        output logic        empty,
        output smne_entry_t head
    );

    smne_entry_t entry_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;

    assign full  = (count_reg == 2'd2);
    assign empty = (count_reg == 2'd0);
    assign head  = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? !rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_entry;
        end
    end

endmodule

@@ hw/rtl/smne_back.sv @@
// Back end: forms the mean by long division and the noise by a bitwise square-root search.
module smne_back
    import smne_pkg::*;
    (
        input  logic                clk,
        input  logic                rst_n,
        input  logic                q_empty,
        input  smne_entry_t         head,
        output logic                pop,
        output logic                done,
        output logic [CH_BITS-1:0]  out_channel,
        output logic [OUT_BITS-1:0] mean_threshold,
        output logic [OUT_BITS-1:0] noise_width,
        output logic [1:0]          status
    );

    smne_back_state_t state_reg, state_next;
    logic [CH_BITS-1:0]      ch_reg, ch_next;
    logic                    wneg_reg, wneg_next, m1neg_reg, m1neg_next, m2neg_reg, m2neg_next;
    logic [W_BITS-1:0]       wmag_reg, wmag_next;
    logic [M1_BITS-1:0]      m1mag_reg, m1mag_next;
    logic [M2_BITS-1:0]      m2mag_reg, m2mag_next;
    logic [55:0]             prod_reg, prod_next;
    logic [31:0]             op_a;
    logic [23:0]             op_b;
    logic [81:0]             acc_reg, acc_next;
    logic [95:0]             q_reg, q_next;
    logic signed [DD_BITS-1:0] dd_reg, dd_next;
    logic [DIV_NUM_BITS-1:0] num_reg, num_next, quo_reg, quo_next;
    logic [DIV_DEN_BITS-1:0] rem_reg, rem_next;
    logic [5:0]              cnt_reg, cnt_next;
    logic [OUT_BITS-1:0]     noise_reg, noise_next;
    logic [3:0]              bit_reg, bit_next;
    logic [65:0]             sq_reg, sq_next;
    logic                    done_reg, done_next;
    logic [CH_BITS-1:0]      och_reg, och_next;
    logic [OUT_BITS-1:0]     mean_reg, mean_next, nout_reg, nout_next;
    logic [1:0]              status_reg, status_next;

    logic [DIV_DEN_BITS:0]   rem_shift;
    logic [DIV_DEN_BITS-1:0] divisor;
    logic [OUT_BITS-1:0]     cand;
    logic [LIM_BITS-1:0]     lim;
    logic [32:0]             xval;

    assign divisor   = {wmag_reg, 1'b0};
    assign rem_shift = {rem_reg, num_reg[DIV_NUM_BITS-1]};
    assign cand      = noise_reg | (OUT_BITS'(1) << bit_reg);
    assign lim       = {dd_reg[DD_BITS-2:0], 8'b0};
    assign xval      = prod_reg[32:0];
    assign prod_next = op_a * op_b;

    assign pop            = (state_reg == B_IDLE) && !q_empty;
    assign done           = done_reg;
    assign out_channel    = och_reg;
    assign mean_threshold = mean_reg;
    assign noise_width    = nout_reg;
    assign status         = status_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= B_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ch_reg     <= ch_next;
        wneg_reg   <= wneg_next;
        m1neg_reg  <= m1neg_next;
        m2neg_reg  <= m2neg_next;
        wmag_reg   <= wmag_next;
        m1mag_reg  <= m1mag_next;
        m2mag_reg  <= m2mag_next;
        prod_reg   <= prod_next;
        acc_reg    <= acc_next;
        q_reg      <= q_next;
        dd_reg     <= dd_next;
        num_reg    <= num_next;
        quo_reg    <= quo_next;
        rem_reg    <= rem_next;
        cnt_reg    <= cnt_next;
        noise_reg  <= noise_next;
        bit_reg    <= bit_next;
        sq_reg     <= sq_next;
        och_reg    <= och_next;
        mean_reg   <= mean_next;
        nout_reg   <= nout_next;
        status_reg <= status_next;
    end

    always_comb
    begin
        state_next  = state_reg;
        ch_next     = ch_reg;
        wneg_next   = wneg_reg;
        m1neg_next  = m1neg_reg;
        m2neg_next  = m2neg_reg;
        wmag_next   = wmag_reg;
        m1mag_next  = m1mag_reg;
        m2mag_next  = m2mag_reg;
        acc_next    = acc_reg;
        q_next      = q_reg;
        dd_next     = dd_reg;
        num_next    = num_reg;
        quo_next    = quo_reg;
        rem_next    = rem_reg;
        cnt_next    = cnt_reg;
        noise_next  = noise_reg;
        bit_next    = bit_reg;
        sq_next     = sq_reg;
        done_next   = 1'b0;
        och_next    = och_reg;
        mean_next   = mean_reg;
        nout_next   = nout_reg;
        status_next = status_reg;
        op_a        = '0;
        op_b        = '0;
        unique case (state_reg)
            B_IDLE:
            begin
                if (!q_empty)
                begin
                    ch_next    = head.channel;
                    wneg_next  = head.w[W_BITS-1];
                    m1neg_next = head.m1[M1_BITS-1];
                    m2neg_next = head.m2[M2_BITS-1];
                    wmag_next  = head.w[W_BITS-1] ? -head.w : head.w;
                    m1mag_next = head.m1[M1_BITS-1] ? -head.m1 : head.m1;
                    m2mag_next = head.m2[M2_BITS-1] ? -head.m2 : head.m2;
                    state_next = B_P0;
                end
            end
            B_P0:
            begin
                op_a       = m2mag_reg[31:0];
                op_b       = {6'b0, wmag_reg};
                state_next = B_P1;
            end
            B_P1:
            begin
                acc_next   = {26'b0, prod_reg};
                op_a       = m2mag_reg[63:32];
                op_b       = {6'b0, wmag_reg};
                state_next = B_P2;
            end
            B_P2:
            begin
                acc_next   = acc_reg + {prod_reg[49:0], 32'b0};
                op_a       = {8'b0, m1mag_reg[23:0]};
                op_b       = m1mag_reg[23:0];
                state_next = B_Q0;
            end
            B_Q0:
            begin
                dd_next    = (m2neg_reg != wneg_reg) ? -$signed({17'b0, acc_reg})
                                                     : $signed({17'b0, acc_reg});
                q_next     = {48'b0, prod_reg[47:0]};
                op_a       = {8'b0, m1mag_reg[47:24]};
                op_b       = m1mag_reg[23:0];
                state_next = B_Q1;
            end
            B_Q1:
            begin
                q_next     = q_reg + {23'b0, prod_reg[47:0], 25'b0};
                op_a       = {8'b0, m1mag_reg[47:24]};
                op_b       = m1mag_reg[47:24];
                state_next = B_Q2;
            end
            B_Q2:
            begin
                q_next     = q_reg + {prod_reg[47:0], 48'b0};
                state_next = B_D;
            end
            B_D:
            begin
                dd_next    = dd_reg - $signed({3'b0, q_reg});
                num_next   = {1'b0, m1mag_reg, 4'b0} + {35'b0, wmag_reg};
                rem_next   = '0;
                quo_next   = '0;
                cnt_next   = '0;
                state_next = B_DIV;
            end
            B_DIV:
            begin
                num_next = {num_reg[DIV_NUM_BITS-2:0], 1'b0};
                if (rem_shift >= {1'b0, divisor})
                begin
                    rem_next = DIV_DEN_BITS'(rem_shift - {1'b0, divisor});
                    quo_next = {quo_reg[DIV_NUM_BITS-2:0], 1'b1};
                end
                else
                begin
                    rem_next = rem_shift[DIV_DEN_BITS-1:0];
                    quo_next = {quo_reg[DIV_NUM_BITS-2:0], 1'b0};
                end
                cnt_next = cnt_reg + 6'd1;
                if (cnt_reg == 6'(DIV_NUM_BITS - 1))
                begin
                    noise_next = '0;
                    bit_next   = 4'(OUT_BITS - 1);
                    state_next = B_SQ_X;
                end
            end
            B_SQ_X:
            begin
                op_a       = {17'b0, cand, 1'b0} - 32'd1;
                op_b       = {6'b0, wmag_reg};
                state_next = B_SQ_M;
            end
            B_SQ_M:
            begin
                sq_next    = xval * xval;
                state_next = B_SQ_C;
            end
            B_SQ_C:
            begin
                if ({40'b0, sq_reg} <= lim)
                begin
                    noise_next = cand;
                end
                if (bit_reg == 4'd0)
                begin
                    state_next = B_OUT;
                end
                else
                begin
                    bit_next   = bit_reg - 4'd1;
                    state_next = B_SQ_X;
                end
            end
            B_OUT:
            begin
                done_next = 1'b1;
                och_next  = ch_reg;
                if (wmag_reg == '0)
                begin
                    mean_next   = '0;
                    nout_next   = '0;
                    status_next = STATUS_ZERO_WT;
                end
                else
                begin
                    if ((m1mag_reg != '0) && (m1neg_reg == wneg_reg))
                    begin
                        mean_next = (quo_reg > DIV_NUM_BITS'(OUT_MAX)) ? OUT_MAX
                                                                       : quo_reg[OUT_BITS-1:0];
                    end
                    else
                    begin
                        mean_next = '0;
                    end
                    if (dd_reg[DD_BITS-1])
                    begin
                        nout_next   = '0;
                        status_next = STATUS_NEG_VAR;
                    end
                    else
                    begin
                        nout_next   = noise_reg;
                        status_next = STATUS_NONE;
                    end
                end
                state_next = B_IDLE;
            end
            default:
            begin
                state_next = B_IDLE;
            end
        endcase
    end

endmodule

@@ hw/rtl/scurve_mean_noise_extractor_unit.sv @@
// Top level of the S-curve mean and noise extractor.
// A request transaction is taken at a rising edge where start is high and busy is low.
// A sample request updates its channel's running sums; a finish request yields one
// result on out_channel, mean_threshold, noise_width and status, marked by done for
// exactly one cycle. The receiver cannot stall, so results are never held back.
// The front end takes a sample by reading its channel's state from the channel RAM, then
// two multiply stages and a write back; the first sample of a channel is only stored.
// A finish request leaves the front end into a two-entry queue; busy rises while that
// queue is full. For each finish the back end takes the entry, forms the partial
// products and the variance difference, runs the long division, makes 14 square-root
// steps and loads the result; it takes the next entry only once it is idle again.
// Requests for a channel at or above CHANNELS are taken and ignored.
// Reset clears the per-channel valid bits at once, so every channel starts empty and
// no clearing pass is needed; the block is ready in the first cycle after reset.
module scurve_mean_noise_extractor_unit
    import smne_pkg::*;
    #(
        parameter int CHANNELS = 256,
        parameter int THRESH_BITS = 10
    )
    (
        input  logic                   clk,
        input  logic                   rst_n,
        input  logic                   start,
        output logic                   busy,
        input  logic                   req_type,
        input  logic [CH_BITS-1:0]     channel,
        input  logic [THRESH_BITS-1:0] threshold,
        input  logic [OCC_BITS-1:0]    occupancy,
        output logic                   done,
        output logic [CH_BITS-1:0]     out_channel,
        output logic [OUT_BITS-1:0]    mean_threshold,
        output logic [OUT_BITS-1:0]    noise_width,
        output logic [1:0]             status
    );

    logic        q_full, q_empty, push, pop;
    smne_entry_t push_entry, head;

    smne_front #(.CHANNELS(CHANNELS), .THRESH_BITS(THRESH_BITS)) u_front
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .busy       (busy),
        .req_type   (req_type),
        .channel    (channel),
        .threshold  (threshold),
        .occupancy  (occupancy),
        .q_full     (q_full),
        .push       (push),
        .push_entry (push_entry)
    );

    smne_queue u_queue
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_entry (push_entry),
        .full       (q_full),
        .pop        (pop),
        .empty      (q_empty),
        .head       (head)
    );

    smne_back u_back
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .q_empty        (q_empty),
        .head           (head),
        .pop            (pop),
        .done           (done),
        .out_channel    (out_channel),
        .mean_threshold (mean_threshold),
        .noise_width    (noise_width),
        .status         (status)
    );

endmodule

@@ bench/scurve_mean_noise_extractor_unit_tb.sv @@
// Self-checking testbench of the S-curve mean and noise extractor, with its own result predictor.
`timescale 1ns / 1ps

module scurve_mean_noise_extractor_unit_tb;
    import smne_pkg::*;

    localparam int NCH = 256;
    localparam int TB = 10;
    localparam int STALL_LIMIT = 4000;

    typedef struct {
        logic [CH_BITS-1:0]  ch;
        logic [OUT_BITS-1:0] mean;
        logic [OUT_BITS-1:0] noise;
        logic [1:0]          st;
    } fit_result_t;

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                start = 1'b0;
    logic                req_type = REQ_SAMPLE;
    logic [CH_BITS-1:0]  channel = '0;
    logic [TB-1:0]       threshold = '0;
    logic [OCC_BITS-1:0] occupancy = '0;
    logic                busy;
    logic                done;
    logic [CH_BITS-1:0]  out_channel;
    logic [OUT_BITS-1:0] mean_threshold;
    logic [OUT_BITS-1:0] noise_width;
    logic [1:0]          status;

    bit          has_prev [NCH];
    bit [TB-1:0] prev_thr [NCH];
    bit [15:0]   prev_occ [NCH];
    bit [17:0]   wsum [NCH];
    bit [47:0]   m1sum [NCH];
    bit [63:0]   m2sum [NCH];

    fit_result_t pending_fits[$];
    int          idle_pct = 0;
    int          failures = 0;
    int          items_sent = 0;
    int          fits_checked = 0;
    int          stall_cycles = 0;

    scurve_mean_noise_extractor_unit dut (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
        .req_type(req_type), .channel(channel), .threshold(threshold),
        .occupancy(occupancy), .done(done), .out_channel(out_channel),
        .mean_threshold(mean_threshold), .noise_width(noise_width), .status(status)
    );

    always #2 clk = ~clk;

    task automatic predict_fit(input logic rq, input logic [7:0] ch, input logic [TB-1:0] t,
                               input logic [15:0] occ);
        longint      d;
        longint      c2;
        bit [17:0]   w;
        bit [47:0]   m1;
        bit [63:0]   m2;
        bit [63:0]   wv;
        bit [63:0]   a;
        bit [63:0]   qv;
        bit [63:0]   x;
        bit [127:0]  p;
        bit [127:0]  q;
        bit [127:0]  dd;
        bit [127:0]  lim;
        bit [127:0]  sq;
        bit          wn;
        bit          m1n;
        bit          m2n;
        bit [13:0]   cand;
        fit_result_t r;
        if (rq == REQ_SAMPLE) begin
            if (has_prev[ch]) begin
                d = longint'(prev_occ[ch]) - longint'(occ);
                c2 = longint'(prev_thr[ch]) + longint'(t);
                wsum[ch] = wsum[ch] + d[17:0];
                m1sum[ch] = m1sum[ch] + 48'(c2 * d);
                m2sum[ch] = m2sum[ch] + 64'(c2 * c2 * d);
            end
            has_prev[ch] = 1'b1;
            prev_thr[ch] = t;
            prev_occ[ch] = occ;
        end else begin
            wn = wsum[ch][17];
            w = wn ? -wsum[ch] : wsum[ch];
            m1n = m1sum[ch][47];
            m1 = m1n ? -m1sum[ch] : m1sum[ch];
            m2n = m2sum[ch][63];
            m2 = m2n ? -m2sum[ch] : m2sum[ch];
            wv = {46'b0, w};
            r.ch = ch;
            r.mean = '0;
            r.noise = '0;
            r.st = STATUS_NONE;
            if (w == 0) begin
                r.st = STATUS_ZERO_WT;
            end else begin
                if (m1 != 0 && m1n == wn) begin
                    a = {13'b0, m1, 3'b0};
                    qv = (2 * a + wv) / (2 * wv);
                    r.mean = (qv > 64'(OUT_MAX)) ? OUT_MAX : qv[13:0];
                end
                p = {64'b0, m2} * {64'b0, wv};
                if (m2n != wn) p = -p;
                q = {80'b0, m1} * {80'b0, m1};
                dd = p - q;
                if (dd[127]) begin
                    r.st = r.st | STATUS_NEG_VAR;
                end else begin
                    lim = dd << 8;
                    for (int b = 13; b >= 0; b--) begin
                        cand = r.noise | (14'd1 << b);
                        x = (64'(cand) * 2 - 1) * wv;
                        sq = {64'b0, x} * {64'b0, x};
                        if (sq <= lim) r.noise = cand;
                    end
                end
            end
            pending_fits.insert(pending_fits.size(), r);
            has_prev[ch] = 1'b0;
            prev_thr[ch] = '0;
            prev_occ[ch] = '0;
            wsum[ch] = '0;
            m1sum[ch] = '0;
            m2sum[ch] = '0;
        end
    endtask

    task automatic send_request(input logic rq, input logic [7:0] ch, input logic [TB-1:0] t,
                                input logic [15:0] occ);
        @(negedge clk);
        while ($urandom_range(99, 0) < idle_pct) begin
            start = 1'b0;
            @(negedge clk);
        end
        start = 1'b1;
        req_type = rq;
        channel = ch;
        threshold = t;
        occupancy = occ;
        @(posedge clk);
        while (busy) @(posedge clk);
        predict_fit(rq, ch, t, occ);
        items_sent++;
    endtask

    task automatic wait_for_fits();
        @(negedge clk);
        start = 1'b0;
        while (pending_fits.size() != 0) @(posedge clk);
    endtask

    task automatic send_scurve(input logic [7:0] ch, input int n);
        int   t;
        int   occ;
        t = $urandom_range(1023, n * 2);
        occ = $urandom_range(32768, 30000);
        for (int i = 0; i < n; i++) begin
            send_request(REQ_SAMPLE, ch, t[TB-1:0], occ[15:0]);
            t = t - $urandom_range(2, 0);
            if (t < 0) t = 0;
            occ = occ - $urandom_range(9000, 0);
            if (occ < 0) occ = $urandom_range(200, 0);
        end
        send_request(REQ_FINISH, ch, TB'($urandom), 16'($urandom));
    endtask

    task automatic test_directed_cases();
        send_request(REQ_FINISH, 8'd0, '0, '0);
        send_request(REQ_SAMPLE, 8'd255, 10'd1023, 16'd32768);
        send_request(REQ_FINISH, 8'd255, '0, '0);
        send_request(REQ_SAMPLE, 8'd1, 10'd600, 16'd32768);
        send_request(REQ_SAMPLE, 8'd1, 10'd500, 16'd0);
        send_request(REQ_FINISH, 8'd1, '1, '1);
        send_request(REQ_SAMPLE, 8'd2, 10'd100, 16'd0);
        send_request(REQ_SAMPLE, 8'd2, 10'd90, 16'd20000);
        send_request(REQ_SAMPLE, 8'd2, 10'd80, 16'd30000);
        send_request(REQ_FINISH, 8'd2, '0, '0);
        send_request(REQ_SAMPLE, 8'd3, 10'd1023, 16'd65535);
        send_request(REQ_SAMPLE, 8'd3, 10'd1022, 16'd0);
        send_request(REQ_SAMPLE, 8'd3, 10'd0, 16'd65534);
        send_request(REQ_FINISH, 8'd3, '0, '0);
        send_request(REQ_SAMPLE, 8'd4, 10'd0, 16'd40000);
        send_request(REQ_SAMPLE, 8'd4, 10'd1023, 16'd20000);
        send_request(REQ_SAMPLE, 8'd4, 10'd2, 16'd39000);
        send_request(REQ_FINISH, 8'd4, '0, '0);
        for (int i = 0; i < 5; i++) send_request(REQ_SAMPLE, 8'd5, 10'd1023, 16'(i[0] ? 0 : 65535));
        send_request(REQ_FINISH, 8'd5, '0, '0);
        wait_for_fits();
    endtask

    task automatic test_random_scurves(input int pct, input int target);
        int goal;
        goal = items_sent + target;
        idle_pct = pct;
        while (items_sent < goal) begin
            if ($urandom_range(9, 0) == 0)
                send_request(1'($urandom), 8'($urandom), TB'($urandom), 16'($urandom));
            else
                send_scurve(8'($urandom), $urandom_range(10, 1));
        end
    endtask

    task automatic test_drain_pause();
        idle_pct = 0;
        for (int k = 0; k < 4; k++) begin
            send_scurve(8'($urandom), $urandom_range(6, 2));
            wait_for_fits();
        end
    endtask

    always @(posedge clk) begin
        fit_result_t e;
        if (done) begin
            if (pending_fits.size() == 0) begin
                $error("unexpected result transaction for channel %0d", out_channel);
                failures++;
            end else begin
                e = pending_fits.pop_front();
                fits_checked++;
                if (out_channel !== e.ch) begin
                    $error("out_channel: expected %0d, got %0d", e.ch, out_channel);
                    failures++;
                end
                if (mean_threshold !== e.mean) begin
                    $error("mean_threshold: expected %0d, got %0d", e.mean, mean_threshold);
                    failures++;
                end
                if (noise_width !== e.noise) begin
                    $error("noise_width: expected %0d, got %0d", e.noise, noise_width);
                    failures++;
                end
                if (status !== e.st) begin
                    $error("status: expected %0d, got %0d", e.st, status);
                    failures++;
                end
            end
        end
    end

    always @(posedge clk) begin
        if ((start && !busy) || done) stall_cycles <= 0;
        else stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= STALL_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    initial begin
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        test_directed_cases();
        test_random_scurves(0, 400);
        test_random_scurves(69, 400);
        test_drain_pause();
        test_random_scurves(15, 400);
        test_random_scurves(0, 400);
        wait_for_fits();
        repeat (200) @(posedge clk);
        if (pending_fits.size() != 0) begin
            $error("%0d expected results never arrived", pending_fits.size());
            failures++;
        end
        $display("Sent %0d request transactions in idle phases of 0, 69 and 15 percent;",
                 items_sent);
        $display("checked %0d fit results, %0d mismatches.", fits_checked, failures);
        if (failures == 0) $display("CHECK OK");
        else $display("CHECK FAILED");
        $finish;
    end

endmodule
